// ===== hw/rtl/utf8d_pkg.sv =====
package utf8d_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned CP_W            = 31;
  localparam int unsigned LEN_W           = 3;
  localparam int unsigned CONT_BITS       = 6;
  localparam int unsigned PAYLOAD_W       = 7;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;

  localparam logic [LEN_W-1:0] LEN_NONE  = 3'd0;
  localparam logic [LEN_W-1:0] LEN_ASCII = 3'd1;

  // Byte class decided by the front end.
  typedef enum logic [1:0] {
    CLS_ASCII,
    CLS_CONT,
    CLS_LEAD,
    CLS_BAD
  } utf8d_cls_e;

  // One classified byte as it travels through the queue.
  typedef struct packed {
    utf8d_cls_e           cls;
    logic [LEN_W-1:0]     lead_len;
    logic [PAYLOAD_W-1:0] payload;
  } utf8d_entry_t;

endpackage

// ===== hw/rtl/utf8d_byte_if.sv =====
interface utf8d_byte_if;
  import utf8d_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

// ===== hw/rtl/utf8d_char_if.sv =====
interface utf8d_char_if;
  import utf8d_pkg::*;

  logic             valid;
  logic             ready;
  logic [CP_W-1:0]  code_point;
  logic [LEN_W-1:0] seq_length;
  logic             bad_sequence;

  modport source (output valid, output code_point, output seq_length, output bad_sequence,
                  input ready);
  modport sink (input valid, input code_point, input seq_length, input bad_sequence,
                output ready);
endinterface

// ===== hw/rtl/utf8d_front.sv =====
module utf8d_front
  import utf8d_pkg::*;
(
  utf8d_byte_if.sink   byte_i,
  input  logic         full_i,
  output logic         push_o,
  output utf8d_entry_t entry_o
);

  logic [BYTE_W-1:0] b;

  assign b            = byte_i.byte_in;
  assign byte_i.ready = !full_i;
  assign push_o       = byte_i.valid && !full_i;

  // Classify by leading ones; keep only the payload bits of the byte.
  always_comb begin
    entry_o.cls      = CLS_BAD;
    entry_o.lead_len = LEN_NONE;
    entry_o.payload  = '0;
    if (!b[7]) begin
      entry_o.cls     = CLS_ASCII;
      entry_o.payload = b[6:0];
    end else if ((b & CONT_MASK) == CONT_TAG) begin
      entry_o.cls     = CLS_CONT;
      entry_o.payload = {1'b0, b[5:0]};
    end else if (b[7:5] == 3'b110) begin
      entry_o.cls      = CLS_LEAD;
      entry_o.lead_len = 3'd2;
      entry_o.payload  = {2'b0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      entry_o.cls      = CLS_LEAD;
      entry_o.lead_len = 3'd3;
      entry_o.payload  = {3'b0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      entry_o.cls      = CLS_LEAD;
      entry_o.lead_len = 3'd4;
      entry_o.payload  = {4'b0, b[2:0]};
    end else if (b[7:2] == 6'b111110) begin
      entry_o.cls      = CLS_LEAD;
      entry_o.lead_len = 3'd5;
      entry_o.payload  = {5'b0, b[1:0]};
    end else if (b[7:1] == 7'b1111110) begin
      entry_o.cls      = CLS_LEAD;
      entry_o.lead_len = 3'd6;
      entry_o.payload  = {6'b0, b[0]};
    end
  end

endmodule

// ===== hw/rtl/utf8d_queue.sv =====
module utf8d_queue
  import utf8d_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  utf8d_entry_t entry_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output utf8d_entry_t entry_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  utf8d_entry_t    mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ptr_inc(wr_q) : wr_q;
    rd_d  = pop_i ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && !valid_o))
    else $error("pop from empty queue");

endmodule

// ===== hw/rtl/utf8d_back.sv =====
module utf8d_back
  import utf8d_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  utf8d_entry_t entry_i,
  output logic         pop_o,
  utf8d_char_if.source char_o
);

  logic [LEN_W-1:0] bytes_left_q, bytes_left_d;
  logic [LEN_W-1:0] total_len_q, total_len_d;
  logic [CP_W-1:0]  acc_q, acc_d;
  logic             out_valid_q, out_valid_d;
  logic [CP_W-1:0]  cp_q, cp_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             bad_q, bad_d;
  logic             emit;
  logic [CP_W-1:0]  acc_shift;

  assign pop_o     = valid_i && (!out_valid_q || char_o.ready);
  assign acc_shift = {acc_q[CP_W-CONT_BITS-1:0], entry_i.payload[CONT_BITS-1:0]};

  always_comb begin
    bytes_left_d = bytes_left_q;
    total_len_d  = total_len_q;
    acc_d        = acc_q;
    emit         = 1'b0;
    cp_d         = cp_q;
    len_d        = len_q;
    bad_d        = bad_q;
    if (pop_o) begin
      if (bytes_left_q != '0) begin
        if (entry_i.cls != CLS_CONT) begin
          // Drop the open sequence together with the offending byte.
          emit         = 1'b1;
          cp_d         = '0;
          len_d        = LEN_NONE;
          bad_d        = 1'b1;
          bytes_left_d = '0;
          total_len_d  = '0;
          acc_d        = '0;
        end else if (bytes_left_q == 3'd1) begin
          emit         = 1'b1;
          cp_d         = acc_shift;
          len_d        = total_len_q;
          bad_d        = 1'b0;
          bytes_left_d = '0;
          total_len_d  = '0;
          acc_d        = '0;
        end else begin
          acc_d        = acc_shift;
          bytes_left_d = bytes_left_q - 1'b1;
        end
      end else begin
        case (entry_i.cls)
          CLS_ASCII: begin
            emit  = 1'b1;
            cp_d  = CP_W'(entry_i.payload);
            len_d = LEN_ASCII;
            bad_d = 1'b0;
          end
          CLS_LEAD: begin
            total_len_d  = entry_i.lead_len;
            bytes_left_d = entry_i.lead_len - 1'b1;
            acc_d        = CP_W'(entry_i.payload);
          end
          default: begin
            emit  = 1'b1;
            cp_d  = '0;
            len_d = LEN_NONE;
            bad_d = 1'b1;
          end
        endcase
      end
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (char_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= '0;
      total_len_q  <= '0;
      acc_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      bytes_left_q <= bytes_left_d;
      total_len_q  <= total_len_d;
      acc_q        <= acc_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q  <= cp_d;
    len_q <= len_d;
    bad_q <= bad_d;
  end

  assign char_o.valid        = out_valid_q;
  assign char_o.code_point   = cp_q;
  assign char_o.seq_length   = len_q;
  assign char_o.bad_sequence = bad_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bytes_left_q != '0) |-> (total_len_q > bytes_left_q && total_len_q <= 3'd6))
    else $error("open sequence bookkeeping inconsistent");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && bad_q) |-> (cp_q == '0 && len_q == LEN_NONE))
    else $error("error result carries data");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !bad_q) |-> (len_q != LEN_NONE))
    else $error("good result without length");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && emit) |=> out_valid_q)
    else $error("result lost");

endmodule

// ===== hw/rtl/utf8_stream_decoder.sv =====
// An accepted byte is written into the queue, then popped by the back end, which registers its
// result (if any) in the output register; an output stall holds bytes in the queue meanwhile.
// Throughput: one byte per cycle unless the output stalls; set by the single-byte decode step.
// Front end classifies into a QUEUE_DEPTH-entry queue; back end pops one a cycle unless stalled.
// The output register frees as it is taken, so a new byte enters in the cycle a result is taken.
// Reset (rst_ni low, asynchronous) empties the queue, closes any open sequence, drops the output.
module utf8_stream_decoder
  import utf8d_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  utf8d_byte_if.sink   byte_i,
  utf8d_char_if.source char_o
);

  // Front end to queue: classified byte and push strobe.
  utf8d_entry_t front_entry;
  logic         front_push;
  logic         queue_full;

  // Queue to back end.
  utf8d_entry_t queue_entry;
  logic         queue_valid;
  logic         back_pop;

  // Classify each byte as it arrives; hold the input off only when the queue is full.
  utf8d_front u_front (
    .byte_i  (byte_i),
    .full_i  (queue_full),
    .push_o  (front_push),
    .entry_o (front_entry)
  );

  // Decouple the two halves so an output stall backs up here first.
  utf8d_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .entry_i (front_entry),
    .full_o  (queue_full),
    .pop_i   (back_pop),
    .valid_o (queue_valid),
    .entry_o (queue_entry)
  );

  // Advance the sequence state, assemble the code point, register the result.
  utf8d_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (queue_valid),
    .entry_i (queue_entry),
    .pop_o   (back_pop),
    .char_o  (char_o)
  );

endmodule
